[design/c3lb_pkg.sv]
package c3lb_pkg;

	localparam int C3LB_MAX_LINE = 2048;

	localparam int PIX_W     = 8;
	localparam int COEF_W    = 24;
	localparam int SHIFT_W   = 5;
	localparam int HEIGHT_W  = 16;
	localparam int WIDTH_W   = 12;
	localparam int CFG_IDX_W = 3;
	localparam int TAP_COUNT = 9;
	localparam int PROD_W    = 17;	// signed 8-bit tap times unsigned 8-bit pixel
	localparam int SUM_W     = 20;	// nine products, worst case about +/-2^18.2

	localparam int PIX_MAX   = 255;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [TAP_COUNT-1:0][PIX_W-1:0] win_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF_TOP,
		REG_COEFF_MIDDLE,
		REG_COEFF_BOTTOM,
		REG_RIGHT_SHIFT,
		REG_MAGNITUDE,
		REG_HEIGHT,
		REG_WIDTH
	} cfg_reg_t;

	typedef struct packed {
		logic [COEF_W-1:0]  row_top;
		logic [COEF_W-1:0]  row_middle;
		logic [COEF_W-1:0]  row_bottom;
		logic [SHIFT_W-1:0] shift;
		logic               magnitude;
	} coef_t;

	// per-word control decided at the input
	typedef struct packed {
		logic col_ok;
		logic use_top;
		logic use_mid;
		logic use_bot;
		logic first;
		logic emit;
		logic last;
	} item_ctl_t;

	typedef struct packed {
		logic emit;
		logic last;
	} res_ctl_t;

endpackage

[design/c3lb_pix_if.sv]
interface c3lb_pix_if;
	import c3lb_pkg::*;

	logic valid;
	logic ready;
	pix_t pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

[design/c3lb_res_if.sv]
interface c3lb_res_if;
	import c3lb_pkg::*;

	logic valid;
	logic ready;
	pix_t result_pixel;
	logic frame_last;

	modport source (output valid, output result_pixel, output frame_last, input ready);
	modport sink (input valid, input result_pixel, input frame_last, output ready);
endinterface

[design/c3lb_cfg_if.sv]
interface c3lb_cfg_if;
	import c3lb_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COEF_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[design/conv3x3_line_buffer_filter.sv]
// 3x3 zero-padded convolution over a raster pixel stream, one word per clock unless stalled.
// From input accept a word passes the s1, s2, s3, s4 and output registers to result valid.
// Throughput: 1 word per cycle; the two line memories give one read and one write per cycle.
// Reset: positions, window and config registers cleared (height and width reset to 1);
// line memories are not cleared and need no clearing pass.
module conv3x3_line_buffer_filter #(
	parameter int MAX_LINE = c3lb_pkg::C3LB_MAX_LINE
) (
	input  logic       clk,
	input  logic       arst_n,
	c3lb_pix_if.sink   pix_in,
	c3lb_res_if.source pix_out,
	c3lb_cfg_if.sink   cfg
);
	import c3lb_pkg::*;

	localparam int AW = $clog2(MAX_LINE);

	// configuration registers
	coef_t               coef_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [WIDTH_W-1:0]  width_q;

	// raster position over the extended (height+1) x (width+1) frame
	logic [HEIGHT_W-1:0] row_q;
	logic [WIDTH_W-1:0]  col_q;

	item_ctl_t     item_ctl;
	logic [AW-1:0] item_addr;
	logic          accept;
	logic          lines_ready;

	logic     win_valid;
	logic     win_ready;
	win_t     win;
	res_ctl_t win_ctl;

	assign cfg.ready    = 1'b1;
	assign pix_in.ready = lines_ready;
	assign accept       = pix_in.valid && lines_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= '0;
			height_q <= HEIGHT_W'(1);
			width_q  <= WIDTH_W'(1);
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_COEFF_TOP:    coef_q.row_top    <= cfg.data;
				REG_COEFF_MIDDLE: coef_q.row_middle <= cfg.data;
				REG_COEFF_BOTTOM: coef_q.row_bottom <= cfg.data;
				REG_RIGHT_SHIFT:  coef_q.shift      <= cfg.data[SHIFT_W-1:0];
				REG_MAGNITUDE:    coef_q.magnitude  <= cfg.data[0];
				REG_HEIGHT:       height_q          <= cfg.data[HEIGHT_W-1:0];
				REG_WIDTH:        width_q           <= cfg.data[WIDTH_W-1:0];
				default:          ;
			endcase
		end
	end

	// Column past the width is the flush column: wrap, and step the row or end the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_q >= width_q) begin
				col_q <= '0;
				row_q <= (row_q >= height_q) ? '0 : row_q + HEIGHT_W'(1);
			end else begin
				col_q <= col_q + WIDTH_W'(1);
			end
		end
	end

	// Per-word control: which window column entries are real pixels,
	// whether a result comes out (row and column both past zero), and end of frame.
	always_comb begin
		item_ctl.col_ok  = (col_q < width_q) && (32'(col_q) < MAX_LINE);
		item_ctl.use_bot = item_ctl.col_ok && (row_q < height_q);
		item_ctl.use_mid = item_ctl.col_ok && (row_q != '0);
		item_ctl.use_top = item_ctl.col_ok && (row_q >= HEIGHT_W'(2));
		item_ctl.first   = (col_q == '0);
		item_ctl.emit    = (row_q != '0) && (col_q != '0);
		item_ctl.last    = (row_q >= height_q) && (col_q >= width_q);
		item_addr        = AW'(col_q);
	end

	// Line memories and the sliding window
	c3lb_lines #(
		.MAX_LINE (MAX_LINE)
	) u_lines (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_ready  (lines_ready),
		.in_ctl    (item_ctl),
		.in_addr   (item_addr),
		.in_pixel  (pix_in.pixel),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win       (win),
		.win_ctl   (win_ctl)
	);

	// Products, sum, shift and clamp; drops words that carry no result
	c3lb_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (coef_q),
		.in_valid (win_valid),
		.in_ready (win_ready),
		.in_win   (win),
		.in_ctl   (win_ctl),
		.res      (pix_out)
	);

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && col_q >= width_q |=> col_q == '0)
		else $error("column did not wrap after flush column");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && col_q < width_q |=> col_q == $past(col_q) + WIDTH_W'(1))
		else $error("column did not advance");

endmodule

[design/c3lb_lines.sv]
module c3lb_lines #(
	parameter int MAX_LINE = c3lb_pkg::C3LB_MAX_LINE,
	localparam int AW = $clog2(MAX_LINE)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  c3lb_pkg::item_ctl_t   in_ctl,
	input  logic [AW-1:0]         in_addr,
	input  c3lb_pkg::pix_t        in_pixel,
	output logic                  win_valid,
	input  logic                  win_ready,
	output c3lb_pkg::win_t        win,
	output c3lb_pkg::res_ctl_t    win_ctl
);
	import c3lb_pkg::*;

	pix_t upper_mem [MAX_LINE];
	pix_t lower_mem [MAX_LINE];

	logic      v_s1;
	item_ctl_t ctl_s1;
	logic [AW-1:0] addr_s1;
	pix_t      pixel_s1;
	pix_t      upper_rd_s1;
	pix_t      lower_rd_s1;

	logic      v_s2;
	res_ctl_t  ctl_s2;
	win_t      win_q;
	win_t      win_nxt;

	pix_t col_top, col_mid, col_bot;
	logic ld_s1, ld_s2, wr_en;

	assign ld_s2    = v_s1 && (!v_s2 || win_ready);
	assign in_ready = !v_s1 || ld_s2;
	assign ld_s1    = in_valid && in_ready;
	assign wr_en    = ld_s2 && ctl_s1.col_ok;

	// line reads, registered
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			upper_rd_s1 <= upper_mem[in_addr];
			lower_rd_s1 <= lower_mem[in_addr];
		end
	end

	// rows move down one line
	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[addr_s1] <= col_mid;
			lower_mem[addr_s1] <= col_bot;
		end
	end

	always_comb begin
		col_top = ctl_s1.use_top ? upper_rd_s1 : '0;
		col_mid = ctl_s1.use_mid ? lower_rd_s1 : '0;
		col_bot = ctl_s1.use_bot ? pixel_s1 : '0;
		for (int r = 0; r < 3; r++) begin
			win_nxt[r*3]   = ctl_s1.first ? '0 : win_q[r*3+1];
			win_nxt[r*3+1] = ctl_s1.first ? '0 : win_q[r*3+2];
		end
		win_nxt[2] = col_top;
		win_nxt[5] = col_mid;
		win_nxt[8] = col_bot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			win_q <= '0;
		end else begin
			if (ld_s1) begin
				v_s1 <= 1'b1;
			end else if (ld_s2) begin
				v_s1 <= 1'b0;
			end
			if (ld_s2) begin
				v_s2  <= 1'b1;
				win_q <= win_nxt;
			end else if (win_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			ctl_s1   <= in_ctl;
			addr_s1  <= in_addr;
			pixel_s1 <= in_pixel;
		end
		if (ld_s2) begin
			ctl_s2 <= '{emit: ctl_s1.emit, last: ctl_s1.last};
		end
	end

	assign win_valid = v_s2;
	assign win       = win_q;
	assign win_ctl   = ctl_s2;

	a_row_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ld_s2 && ctl_s1.first |=> win_q[0] == '0 && win_q[1] == '0 && win_q[3] == '0
			&& win_q[4] == '0 && win_q[6] == '0 && win_q[7] == '0)
		else $error("window not cleared at row start");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && ld_s1 && in_ctl.col_ok |-> addr_s1 != in_addr)
		else $error("line write and read hit the same column");

endmodule

[design/c3lb_mac.sv]
module c3lb_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  c3lb_pkg::coef_t    coef,
	input  logic               in_valid,
	output logic               in_ready,
	input  c3lb_pkg::win_t     in_win,
	input  c3lb_pkg::res_ctl_t in_ctl,
	c3lb_res_if.source         res
);
	import c3lb_pkg::*;

	logic signed [PIX_W-1:0] tap [TAP_COUNT];
	logic [TAP_COUNT-1:0][PROD_W-1:0] prod_c;
	logic signed [SUM_W-1:0] ext [TAP_COUNT];
	logic signed [SUM_W-1:0] sum_c;
	logic signed [SUM_W-1:0] shifted;
	logic signed [SUM_W-1:0] val;
	pix_t                    clamp_c;

	logic v_s3, v_s4, v_out_q;
	logic [TAP_COUNT-1:0][PROD_W-1:0] prod_s3;
	res_ctl_t ctl_s3, ctl_s4;
	logic signed [SUM_W-1:0] sum_s4;
	pix_t res_q;
	logic last_q;

	logic ld_s3, ld_s4, ld_out;

	assign ld_out   = v_s4 && ctl_s4.emit && (!v_out_q || res.ready)
		|| v_s4 && !ctl_s4.emit;
	assign ld_s4    = v_s3 && (!v_s4 || ld_out);
	assign in_ready = !v_s3 || ld_s4;
	assign ld_s3    = in_valid && in_ready;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tap[k]   = $signed(coef.row_top[PIX_W*k +: PIX_W]);
			tap[3+k] = $signed(coef.row_middle[PIX_W*k +: PIX_W]);
			tap[6+k] = $signed(coef.row_bottom[PIX_W*k +: PIX_W]);
		end
		for (int t = 0; t < TAP_COUNT; t++) begin
			prod_c[t] = PROD_W'(tap[t] * $signed({1'b0, in_win[t]}));
			ext[t]    = SUM_W'($signed(prod_s3[t]));
		end
		sum_c = ext[0] + ext[1] + ext[2] + ext[3] + ext[4] + ext[5] + ext[6] + ext[7] + ext[8];
	end

	// floor shift, optional magnitude, clamp to a pixel
	always_comb begin
		shifted = sum_s4 >>> coef.shift;
		val     = (coef.magnitude && shifted < 0) ? -shifted : shifted;
		if (val < 0) begin
			clamp_c = '0;
		end else if (val > SUM_W'(PIX_MAX)) begin
			clamp_c = pix_t'(PIX_MAX);
		end else begin
			clamp_c = val[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (ld_s3) begin
				v_s3 <= 1'b1;
			end else if (ld_s4) begin
				v_s3 <= 1'b0;
			end
			if (ld_s4) begin
				v_s4 <= 1'b1;
			end else if (ld_out) begin
				v_s4 <= 1'b0;
			end
			if (ld_out && ctl_s4.emit) begin
				v_out_q <= 1'b1;
			end else if (res.ready) begin
				v_out_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			prod_s3 <= prod_c;
			ctl_s3  <= in_ctl;
		end
		if (ld_s4) begin
			sum_s4 <= sum_c;
			ctl_s4 <= ctl_s3;
		end
		if (ld_out && ctl_s4.emit) begin
			res_q  <= clamp_c;
			last_q <= ctl_s4.last;
		end
	end

	assign res.valid        = v_out_q;
	assign res.result_pixel = res_q;
	assign res.frame_last   = last_q;

	a_prod_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !ld_s4 |=> $stable(prod_s3))
		else $error("product stage overwritten while stalled");

endmodule
